### rtl/core/led_blink_pattern_engine_core_defines.svh
// ----------------------------------------------------------------------------
// led blink pattern engine assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_PATTERN_ENGINE_CORE_DEFINES_SVH
`define LED_BLINK_PATTERN_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define LBPE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("lbpe assertion failed");
// same-cycle implication
`define LBPE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lbpe implication failed");
`else
`define LBPE_ASSERT(lbl, clk, rstn, prop)
`define LBPE_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/core/lbpe_pkg.sv
// ----------------------------------------------------------------------------
// lbpe_pkg
// shared types, codes and constants of the led blink pattern engine
// ----------------------------------------------------------------------------
`default_nettype none

package lbpe_pkg;

  // default parameter values
  localparam int unsigned INTERVAL_BITS_DEF  = 16;
  localparam int unsigned DURATION_BITS_DEF  = 24;
  localparam int unsigned STROBE_FLASHES_DEF = 5;
  localparam int unsigned FADE_STEP_DEF      = 5;

  // fixed field widths
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned LEVEL_IN_W  = 10;

  // timing constants in ms
  localparam int unsigned SLOW_MS         = 1000;
  localparam int unsigned FAST_MS         = 200;
  localparam int unsigned HEART_ON_MS     = 100;
  localparam int unsigned HEART_PAUSE_MS  = 800;
  localparam int unsigned STROBE_MS       = 50;
  localparam int unsigned STROBE_PAUSE_MS = 1000;
  localparam int unsigned FADE_MS         = 50;
  localparam int unsigned RESET_IV_MS     = 500;
  localparam int unsigned HEART_FLASHES   = 2;

  localparam logic [7:0] LEVEL_MAX = 8'd255;

  // request codes
  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_START  = 3'd1,
    REQ_STOP   = 3'd2,
    REQ_ON     = 3'd3,
    REQ_OFF    = 3'd4,
    REQ_TOGGLE = 3'd5,
    REQ_SET    = 3'd6,
    REQ_ADJUST = 3'd7
  } req_e;

  // pattern modes
  typedef enum logic [2:0] {
    MODE_SOLID  = 3'd0,
    MODE_SLOW   = 3'd1,
    MODE_FAST   = 3'd2,
    MODE_HEART  = 3'd3,
    MODE_FADE   = 3'd4,
    MODE_STROBE = 3'd5,
    MODE_CUSTOM = 3'd6
  } mode_e;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_MODE = 3'd0,
    CFG_CUSTOM_IV    = 3'd1,
    CFG_IV_OVERRIDE  = 3'd2,
    CFG_DURATION     = 3'd3,
    CFG_PWM_CAPABLE  = 3'd4
  } cfg_idx_e;

  // configuration register bank
  typedef struct packed {
    logic [2:0]  pattern_mode;
    logic [15:0] custom_interval;
    logic        interval_override;
    logic [23:0] duration_limit;
    logic        pwm_capable;
  } cfg_t;

  // led status handed to the result register
  typedef struct packed {
    logic       lit;
    logic [7:0] level;
    logic       running;
  } status_t;

  // clamp a signed value to 0..255
  function automatic logic [7:0] sat_level(input logic signed [10:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 11'sd255) begin
      r = LEVEL_MAX;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/lbpe_cfg_regs.sv
// ----------------------------------------------------------------------------
// lbpe_cfg_regs
// configuration register bank, written through its own valid/ready channel
// ----------------------------------------------------------------------------
`default_nettype none

module lbpe_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [lbpe_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [lbpe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output lbpe_pkg::cfg_t                       cfg_o
);
  import lbpe_pkg::*;

  cfg_t cfg_q, cfg_d;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // register decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PATTERN_MODE: cfg_d.pattern_mode      = cfg_data_i[2:0];
        CFG_CUSTOM_IV:    cfg_d.custom_interval   = cfg_data_i[15:0];
        CFG_IV_OVERRIDE:  cfg_d.interval_override = cfg_data_i[0];
        CFG_DURATION:     cfg_d.duration_limit    = cfg_data_i[23:0];
        CFG_PWM_CAPABLE:  cfg_d.pwm_capable       = cfg_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  // register bank
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_mode      <= MODE_SOLID;
      cfg_q.custom_interval   <= 16'(RESET_IV_MS);
      cfg_q.interval_override <= 1'b0;
      cfg_q.duration_limit    <= 24'd0;
      cfg_q.pwm_capable       <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/core/lbpe_engine.sv
// ----------------------------------------------------------------------------
// lbpe_engine
// led state registers and the per-item next-state logic for ticks and commands
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_blink_pattern_engine_core_defines.svh"

module lbpe_engine #(
  parameter int unsigned INTERVAL_BITS  = lbpe_pkg::INTERVAL_BITS_DEF,
  parameter int unsigned DURATION_BITS  = lbpe_pkg::DURATION_BITS_DEF,
  parameter int unsigned STROBE_FLASHES = lbpe_pkg::STROBE_FLASHES_DEF,
  parameter int unsigned FADE_STEP      = lbpe_pkg::FADE_STEP_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  accept_i,
  input  wire logic [2:0]                            req_type_i,
  input  wire logic signed [lbpe_pkg::LEVEL_IN_W-1:0] level_i,
  input  wire lbpe_pkg::cfg_t                        cfg_i,
  output lbpe_pkg::status_t                          status_o
);
  import lbpe_pkg::*;

  localparam int unsigned IB = INTERVAL_BITS;
  localparam int unsigned DB = DURATION_BITS;

  localparam logic [IB-1:0] IV_SLOW         = IB'(SLOW_MS);
  localparam logic [IB-1:0] IV_FAST         = IB'(FAST_MS);
  localparam logic [IB-1:0] IV_HEART_ON     = IB'(HEART_ON_MS);
  localparam logic [IB-1:0] IV_HEART_PAUSE  = IB'(HEART_PAUSE_MS);
  localparam logic [IB-1:0] IV_STROBE       = IB'(STROBE_MS);
  localparam logic [IB-1:0] IV_STROBE_PAUSE = IB'(STROBE_PAUSE_MS);
  localparam logic [IB-1:0] IV_FADE         = IB'(FADE_MS);
  localparam logic [IB-1:0] IV_RESET        = IB'(RESET_IV_MS);
  localparam logic [2:0]    STROBE_N        = 3'(STROBE_FLASHES);
  localparam logic [2:0]    HEART_N         = 3'(HEART_FLASHES);
  localparam logic [9:0]    FADE_INC        = 10'(FADE_STEP);

  logic            lit_q, lit_d;
  logic [7:0]      level_q, level_d;
  logic            running_q, running_d;
  mode_e           mode_q, mode_d;
  logic [IB-1:0]   step_iv_q, step_iv_d;
  logic [IB-1:0]   since_step_q, since_step_d;
  logic [DB-1:0]   since_start_q, since_start_d;
  logic [2:0]      flash_q, flash_d;
  logic            rising_q, rising_d;

  logic [31:0]     ci_wide, dur_wide;
  logic [IB-1:0]   custom_iv;
  logic [DB-1:0]   dur_lim;
  logic [DB-1:0]   start_inc;
  logic [IB-1:0]   step_inc;
  logic [IB-1:0]   start_iv;
  logic [9:0]      fade_up;
  logic signed [10:0] adj_sum;

  // config values at the counter widths
  assign ci_wide   = 32'(cfg_i.custom_interval);
  assign dur_wide  = 32'(cfg_i.duration_limit);
  assign custom_iv = ci_wide[IB-1:0];
  assign dur_lim   = dur_wide[DB-1:0];

  // saturating counter increments
  assign start_inc = (since_start_q != '1) ? since_start_q + 1'b1 : since_start_q;
  assign step_inc  = (since_step_q != '1) ? since_step_q + 1'b1 : since_step_q;

  // fade ramp and brightness adjust sums
  assign fade_up = {2'b00, level_q} + FADE_INC;
  assign adj_sum = $signed({3'b000, level_q}) + $signed({level_i[9], level_i});

  // default interval of the configured pattern, or the custom one on override
  always_comb begin
    case (cfg_i.pattern_mode)
      MODE_SLOW:   start_iv = IV_SLOW;
      MODE_FAST:   start_iv = IV_FAST;
      MODE_HEART:  start_iv = IV_HEART_ON;
      MODE_FADE:   start_iv = IV_FADE;
      MODE_STROBE: start_iv = IV_STROBE;
      MODE_CUSTOM: start_iv = custom_iv;
      default:     start_iv = custom_iv;
    endcase
    if (cfg_i.interval_override) begin
      start_iv = custom_iv;
    end
  end

  // next state for one item
  always_comb begin
    lit_d         = lit_q;
    level_d       = level_q;
    running_d     = running_q;
    mode_d        = mode_q;
    step_iv_d     = step_iv_q;
    since_step_d  = since_step_q;
    since_start_d = since_start_q;
    flash_d       = flash_q;
    rising_d      = rising_q;

    case (req_type_i)
      REQ_TICK: begin
        if (running_q) begin
          since_start_d = start_inc;
          if ((cfg_i.duration_limit != '0) && (start_inc >= dur_lim)) begin
            // run time used up
            running_d = 1'b0;
            mode_d    = MODE_SOLID;
            lit_d     = 1'b0;
          end else begin
            since_step_d = step_inc;
            if (step_inc >= step_iv_q) begin
              since_step_d = '0;
              // one pattern step
              case (mode_q)
                MODE_SLOW, MODE_FAST, MODE_CUSTOM: begin
                  lit_d = ~lit_q;
                end
                MODE_HEART: begin
                  if (flash_q < HEART_N) begin
                    lit_d     = ~lit_q;
                    flash_d   = flash_q + 3'd1;
                    step_iv_d = IV_HEART_ON;
                  end else begin
                    flash_d   = 3'd0;
                    step_iv_d = IV_HEART_PAUSE;
                    lit_d     = 1'b0;
                  end
                end
                MODE_FADE: begin
                  if (!cfg_i.pwm_capable) begin
                    lit_d = ~lit_q;
                  end else begin
                    lit_d = 1'b1;
                    if (rising_q) begin
                      if (fade_up >= 10'd255) begin
                        level_d  = LEVEL_MAX;
                        rising_d = 1'b0;
                      end else begin
                        level_d = fade_up[7:0];
                      end
                    end else begin
                      if ({2'b00, level_q} <= FADE_INC) begin
                        level_d  = 8'd0;
                        rising_d = 1'b1;
                      end else begin
                        level_d = level_q - FADE_INC[7:0];
                      end
                    end
                  end
                end
                MODE_STROBE: begin
                  if (flash_q < STROBE_N) begin
                    lit_d     = ~lit_q;
                    flash_d   = flash_q + 3'd1;
                    step_iv_d = IV_STROBE;
                  end else begin
                    flash_d   = 3'd0;
                    step_iv_d = IV_STROBE_PAUSE;
                    lit_d     = 1'b0;
                  end
                end
                default: begin
                  lit_d = lit_q;
                end
              endcase
            end
          end
        end
      end
      REQ_START: begin
        case (cfg_i.pattern_mode)
          MODE_SLOW, MODE_FAST, MODE_HEART, MODE_FADE, MODE_STROBE, MODE_CUSTOM: begin
            mode_d        = mode_e'(cfg_i.pattern_mode);
            step_iv_d     = start_iv;
            running_d     = 1'b1;
            since_step_d  = '0;
            since_start_d = '0;
            flash_d       = 3'd0;
            if (cfg_i.pattern_mode == MODE_FADE) begin
              rising_d = 1'b1;
            end
          end
          default: begin
            // solid: no pattern, led on
            running_d = 1'b0;
            mode_d    = MODE_SOLID;
            lit_d     = 1'b1;
          end
        endcase
      end
      REQ_STOP, REQ_OFF: begin
        running_d = 1'b0;
        mode_d    = MODE_SOLID;
        lit_d     = 1'b0;
      end
      REQ_ON: begin
        running_d = 1'b0;
        mode_d    = MODE_SOLID;
        lit_d     = 1'b1;
      end
      REQ_TOGGLE: begin
        lit_d = ~lit_q;
      end
      REQ_SET: begin
        level_d = sat_level({level_i[9], level_i});
      end
      REQ_ADJUST: begin
        level_d = sat_level(adj_sum);
      end
      default: begin
        lit_d = lit_q;
      end
    endcase
  end

  // state registers, updated on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q         <= 1'b0;
      level_q       <= LEVEL_MAX;
      running_q     <= 1'b0;
      mode_q        <= MODE_SOLID;
      step_iv_q     <= IV_RESET;
      since_step_q  <= '0;
      since_start_q <= '0;
      flash_q       <= 3'd0;
      rising_q      <= 1'b1;
    end else if (accept_i) begin
      lit_q         <= lit_d;
      level_q       <= level_d;
      running_q     <= running_d;
      mode_q        <= mode_d;
      step_iv_q     <= step_iv_d;
      since_step_q  <= since_step_d;
      since_start_q <= since_start_d;
      flash_q       <= flash_d;
      rising_q      <= rising_d;
    end
  end

  // status after this item goes to the result register
  assign status_o.lit     = lit_d;
  assign status_o.level   = level_d;
  assign status_o.running = running_d;

  // a running pattern always has a timed mode
  `LBPE_ASSERT_IMPL(a_run_mode, clk_i, rst_ni, running_q, mode_q != MODE_SOLID)
  // heartbeat never exceeds its flash count
  `LBPE_ASSERT_IMPL(a_heart_flash, clk_i, rst_ni, running_q && (mode_q == MODE_HEART),
                    flash_q <= HEART_N)
  // strobe never exceeds its flash count
  `LBPE_ASSERT_IMPL(a_strobe_flash, clk_i, rst_ni, running_q && (mode_q == MODE_STROBE),
                    flash_q <= STROBE_N)

endmodule

`default_nettype wire

### rtl/core/lbpe_result_reg.sv
// ----------------------------------------------------------------------------
// lbpe_result_reg
// result register with output handshake and drive level selection
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_blink_pattern_engine_core_defines.svh"

module lbpe_result_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  output logic                   in_ready_o,
  input  wire lbpe_pkg::status_t status_i,
  input  wire logic              pwm_capable_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             drive_level_o,
  output logic                   led_on_o,
  output logic [7:0]             brightness_now_o,
  output logic                   pattern_running_o
);
  import lbpe_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] drive_q, drive_d;
  logic       on_q;
  logic [7:0] bright_q;
  logic       run_q;

  // room for a new item when empty or being drained
  assign in_ready_o = !valid_q || out_ready_i;

  // duty for the led output
  always_comb begin
    if (!status_i.lit) begin
      drive_d = 8'd0;
    end else if (pwm_capable_i) begin
      drive_d = status_i.level;
    end else begin
      drive_d = LEVEL_MAX;
    end
  end

  // valid flag
  always_comb begin
    valid_d = valid_q;
    if (accept_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      drive_q  <= drive_d;
      on_q     <= status_i.lit;
      bright_q <= status_i.level;
      run_q    <= status_i.running;
    end
  end

  assign out_valid_o       = valid_q;
  assign drive_level_o     = drive_q;
  assign led_on_o          = on_q;
  assign brightness_now_o  = bright_q;
  assign pattern_running_o = run_q;

  // an unlit item always drives zero
  `LBPE_ASSERT_IMPL(a_off_zero, clk_i, rst_ni, valid_q && !on_q, drive_q == 8'd0)

endmodule

`default_nettype wire

### rtl/core/led_blink_pattern_engine_core.sv
// ----------------------------------------------------------------------------
// led_blink_pattern_engine_core
// one-led blink, heartbeat, strobe and fade pattern engine driven by tick
// and command items
// result: valid in the cycle after its item is accepted
// throughput: one item per cycle unless out_ready_i stalls the output, set by
//   the single next-state pass between the state and result registers
// reset: asynchronous, clears all but the result payload to defaults at once,
//   no clearing pass; configuration writes are taken every cycle
// ----------------------------------------------------------------------------
`default_nettype none

module led_blink_pattern_engine_core #(
  parameter int unsigned INTERVAL_BITS  = lbpe_pkg::INTERVAL_BITS_DEF,
  parameter int unsigned DURATION_BITS  = lbpe_pkg::DURATION_BITS_DEF,
  parameter int unsigned STROBE_FLASHES = lbpe_pkg::STROBE_FLASHES_DEF,
  parameter int unsigned FADE_STEP      = lbpe_pkg::FADE_STEP_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration write channel
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [lbpe_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  wire logic [lbpe_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // input items
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [2:0]                            req_type_i,
  input  wire logic signed [lbpe_pkg::LEVEL_IN_W-1:0] level_i,
  // result items
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [7:0]                                 drive_level_o,
  output logic                                       led_on_o,
  output logic [7:0]                                 brightness_now_o,
  output logic                                       pattern_running_o
);
  import lbpe_pkg::*;

  cfg_t    cfg;
  status_t status;
  logic    accept;

  assign accept = in_valid_i && in_ready_o;

  // configuration registers
  lbpe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // led state and pattern sequencing
  lbpe_engine #(
    .INTERVAL_BITS  (INTERVAL_BITS),
    .DURATION_BITS  (DURATION_BITS),
    .STROBE_FLASHES (STROBE_FLASHES),
    .FADE_STEP      (FADE_STEP)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .level_i    (level_i),
    .cfg_i      (cfg),
    .status_o   (status)
  );

  // result register
  lbpe_result_reg u_result (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .in_ready_o        (in_ready_o),
    .status_i          (status),
    .pwm_capable_i     (cfg.pwm_capable),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .drive_level_o     (drive_level_o),
    .led_on_o          (led_on_o),
    .brightness_now_o  (brightness_now_o),
    .pattern_running_o (pattern_running_o)
  );

endmodule

`default_nettype wire
